// File: rtl/core/tsp_pkg.sv
// Shared constants, codes and tables of the tone sequence player.
package tsp_pkg;

  // Sequence store
  localparam int SEQ_DEPTH = 64;
  localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
  localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

  // Field widths
  localparam int REF_W    = 18;
  localparam int FREQ_W   = 24;
  localparam int DUR_W    = 24;
  localparam int PER_W    = 16;
  localparam int SEMI_W   = 16;
  localparam int PROD_W   = REF_W + SEMI_W;
  localparam int NORM_W   = PROD_W + 6;
  localparam int NUM_W    = 32;
  localparam int IDX_W    = 7;

  // Stream widths
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 48;

  // Constants
  localparam logic [REF_W-1:0] REF_RESET = 18'd112640;
  localparam logic [NUM_W-1:0] PERIOD_NUM = 32'd4096000000;
  localparam logic [PER_W-1:0] TOP_MAX = 16'd65535;
  localparam logic [PER_W-1:0] TOP_MIN = 16'd256;
  localparam logic [DUR_W-1:0] DUR_MAX = 24'hFFFFFF;

  // Item function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_STOP  = 2'd2;
  localparam logic [1:0] FN_TICK  = 2'd3;

  // Semitone ratio 2^(s/12) in Q15
  function automatic logic [SEMI_W-1:0] semitone_q15(input logic [3:0] s);
    logic [SEMI_W-1:0] r;
    unique case (s)
      4'd0:    r = 16'd32768;
      4'd1:    r = 16'd34716;
      4'd2:    r = 16'd36781;
      4'd3:    r = 16'd38968;
      4'd4:    r = 16'd41285;
      4'd5:    r = 16'd43740;
      4'd6:    r = 16'd46341;
      4'd7:    r = 16'd49096;
      4'd8:    r = 16'd52016;
      4'd9:    r = 16'd55109;
      4'd10:   r = 16'd58386;
      4'd11:   r = 16'd61858;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/tone_sequence_player.sv
// Top level of the tone sequence player: command decode, serial math and playback.
//
// Usage: items enter on the s_axis channel; tuser carries the function code
// (load entry, start, stop, millisecond tick) and the note/frequency select,
// tdata the entry payload. Every item gives exactly one status item on the
// m_axis channel: PWM period and compare value, tone flag, playing flag,
// current entry index and a store-full flag for dropped loads.
// The A4 reference pitch is written on the cfg channel, which is always ready;
// write it only while no item is in flight.
// Work done per item after acceptance:
//   start / stop: the status item directly; tick: a registered store read, then the status item;
//   frequency load: a store-full check, the 32-step bit-serial divider and a store write;
//   note load: the same, with a 16-step shift-add multiplier before the divider.
// One item is worked on at a time; the input is ready again in the cycle after the
// status item is written.
// A new item is taken while the previous status item still waits in
// the output register; a stalled receiver only holds the block in its final
// step until the output register frees up.
// Reset: reference pitch 440 Hz, empty sequence, tone released (period 65535),
// no status item pending. The sequence store itself is not cleared and needs
// no clearing pass; only written entries are ever used.
module tone_sequence_player (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_entry, frequency_q8, note_letter, note_octave, is_rest, duration_ms, indefinite
  input  logic [tsp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // func, use_note
  input  logic [tsp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // Status items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // timer_top, compare_value, tone_on, playing, note_index, table_full
  output logic [tsp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // Reference pitch write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsp_pkg::REF_W-1:0]      cfg_data_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LDCHK  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_NORM   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_STORE  = 3'd5;
  localparam logic [2:0] ST_TICK   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  // Control state
  logic [2:0]                     state_q, state_d;
  logic [tsp_pkg::REF_W-1:0]      ref_q, ref_d;
  logic [tsp_pkg::CNT_W-1:0]      count_q, count_d;
  logic [tsp_pkg::CNT_W-1:0]      ptr_q, ptr_d;
  logic                           phase_q, phase_d;
  logic [tsp_pkg::DUR_W-1:0]      elapsed_q, elapsed_d;
  logic [tsp_pkg::PER_W-1:0]      top_q, top_d;
  logic                           active_q, active_d;
  logic                           full_q, full_d;
  logic                           out_valid_q, out_valid_d;

  // Payload registers
  logic [tsp_pkg::M_TDATA_W-1:0]  out_data_q, out_data_d;
  logic                           use_note_q, use_note_d;
  logic [tsp_pkg::FREQ_W-1:0]     freq_in_q, freq_in_d;
  logic [3:0]                     letter_q, letter_d;
  logic [3:0]                     octave_q, octave_d;
  logic                           rest_q, rest_d;
  logic [tsp_pkg::DUR_W-1:0]      dur_q, dur_d;
  logic                           indef_q, indef_d;
  logic [tsp_pkg::PROD_W-1:0]     mcand_q, mcand_d;
  logic [tsp_pkg::SEMI_W-1:0]     mpl_q, mpl_d;
  logic [tsp_pkg::PROD_W-1:0]     acc_q, acc_d;
  logic [2:0]                     shamt_q, shamt_d;
  logic [4:0]                     step_q, step_d;
  logic [tsp_pkg::FREQ_W-1:0]     divisor_q, divisor_d;
  logic [tsp_pkg::FREQ_W-1:0]     rem_q, rem_d;
  logic [tsp_pkg::NUM_W-1:0]      num_q, num_d;

  // Sequence store
  logic [tsp_pkg::PER_W:0]        per_mem [tsp_pkg::SEQ_DEPTH];
  logic [tsp_pkg::DUR_W:0]        dur_mem [tsp_pkg::SEQ_DEPTH];
  logic [tsp_pkg::PER_W:0]        rd_per_q;
  logic [tsp_pkg::DUR_W:0]        rd_dur_q;
  logic                           mem_we;
  logic [tsp_pkg::PER_W-1:0]      per_clamped;

  // Datapath helpers
  logic                           in_fire;
  logic [1:0]                     in_func;
  logic [3:0]                     letter_c, octave_c, semi_raw, semi_idx;
  logic                           semi_wrap;
  logic [tsp_pkg::NORM_W-1:0]     norm_w;
  logic [tsp_pkg::FREQ_W:0]       trial;
  logic [tsp_pkg::FREQ_W+1:0]     diff;
  logic                           quo_bit;
  logic [tsp_pkg::DUR_W-1:0]      el_next;
  logic [tsp_pkg::CNT_W-1:0]      ptr_inc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_func       = s_axis_tuser[1:0];
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Note tuning: clamp letter and octave, fold letter+3 into a semitone and octave shift
  assign letter_c  = (letter_q > 4'd11) ? 4'd11 : letter_q;
  assign octave_c  = (octave_q < 4'd2) ? 4'd2 : ((octave_q > 4'd7) ? 4'd7 : octave_q);
  assign semi_raw  = letter_c + 4'd3;
  assign semi_wrap = (semi_raw >= 4'd12);
  assign semi_idx  = semi_wrap ? (semi_raw - 4'd12) : semi_raw;

  // Frequency = (ref * ratio) << shift >> 18
  assign norm_w = {6'b0, acc_q} << shamt_q;

  // One restoring-division step
  assign trial   = {rem_q, num_q[tsp_pkg::NUM_W-1]};
  assign diff    = {1'b0, trial} - {2'b0, divisor_q};
  assign quo_bit = !diff[tsp_pkg::FREQ_W+1];

  // Clamp the quotient into the PWM period range
  always_comb begin
    priority if (|num_q[tsp_pkg::NUM_W-1:tsp_pkg::PER_W]) begin
      per_clamped = tsp_pkg::TOP_MAX;
    end else if (num_q[tsp_pkg::PER_W-1:8] == 8'd0) begin
      per_clamped = tsp_pkg::TOP_MIN;
    end else begin
      per_clamped = num_q[tsp_pkg::PER_W-1:0];
    end
  end

  assign el_next = phase_q ? ((elapsed_q != tsp_pkg::DUR_MAX) ? elapsed_q + 1'b1 : elapsed_q)
                           : '0;
  assign ptr_inc = ptr_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    ref_d       = ref_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    top_d       = top_q;
    active_d    = active_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    use_note_d  = use_note_q;
    freq_in_d   = freq_in_q;
    letter_d    = letter_q;
    octave_d    = octave_q;
    rest_d      = rest_q;
    dur_d       = dur_q;
    indef_d     = indef_q;
    mcand_d     = mcand_q;
    mpl_d       = mpl_q;
    acc_d       = acc_q;
    shamt_d     = shamt_q;
    step_d      = step_q;
    divisor_d   = divisor_q;
    rem_d       = rem_q;
    num_d       = num_q;
    mem_we      = 1'b0;

    if (cfg_valid_i) begin
      ref_d = cfg_data_i;
    end

    // Drop the status item once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          use_note_d = s_axis_tuser[2];
          freq_in_d  = s_axis_tdata[24:1];
          letter_d   = s_axis_tdata[28:25];
          octave_d   = s_axis_tdata[32:29];
          rest_d     = s_axis_tdata[33];
          dur_d      = s_axis_tdata[57:34];
          indef_d    = s_axis_tdata[58];
          full_d     = 1'b0;
          unique case (in_func)
            tsp_pkg::FN_LOAD: begin
              if (s_axis_tdata[0]) begin
                count_d  = '0;
                ptr_d    = '0;
                phase_d  = 1'b0;
                top_d    = tsp_pkg::TOP_MAX;
                active_d = 1'b0;
              end
              state_d = ST_LDCHK;
            end
            tsp_pkg::FN_START: begin
              ptr_d     = '0;
              phase_d   = 1'b0;
              elapsed_d = '0;
              state_d   = ST_FINISH;
            end
            tsp_pkg::FN_STOP: begin
              ptr_d    = count_q;
              top_d    = tsp_pkg::TOP_MAX;
              active_d = 1'b0;
              state_d  = ST_FINISH;
            end
            tsp_pkg::FN_TICK: begin
              if (ptr_q < count_q) begin
                state_d = ST_TICK;
              end else begin
                top_d    = tsp_pkg::TOP_MAX;
                active_d = 1'b0;
                state_d  = ST_FINISH;
              end
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end

      ST_LDCHK: begin
        if (count_q == tsp_pkg::CNT_W'(tsp_pkg::SEQ_DEPTH)) begin
          full_d  = 1'b1;
          state_d = ST_FINISH;
        end else if (use_note_q) begin
          mcand_d = {{tsp_pkg::SEMI_W{1'b0}}, ref_q};
          mpl_d   = tsp_pkg::semitone_q15(semi_idx);
          acc_d   = '0;
          shamt_d = 3'(octave_c - 4'd2) + {2'b0, semi_wrap};
          step_d  = 5'd15;
          state_d = ST_MUL;
        end else begin
          divisor_d = freq_in_q;
          rem_d     = '0;
          num_d     = tsp_pkg::PERIOD_NUM;
          step_d    = 5'd31;
          state_d   = ST_DIV;
        end
      end

      ST_MUL: begin
        // Add one multiplier bit per cycle
        if (mpl_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = {mcand_q[tsp_pkg::PROD_W-2:0], 1'b0};
        mpl_d   = {1'b0, mpl_q[tsp_pkg::SEMI_W-1:1]};
        step_d  = step_q - 1'b1;
        if (step_q == 5'd0) begin
          state_d = ST_NORM;
        end
      end

      ST_NORM: begin
        divisor_d = {2'b0, norm_w[tsp_pkg::NORM_W-1:18]};
        rem_d     = '0;
        num_d     = tsp_pkg::PERIOD_NUM;
        step_d    = 5'd31;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        // One quotient bit per cycle; a zero divisor yields all ones
        rem_d  = quo_bit ? diff[tsp_pkg::FREQ_W-1:0] : trial[tsp_pkg::FREQ_W-1:0];
        num_d  = {num_q[tsp_pkg::NUM_W-2:0], quo_bit};
        step_d = step_q - 1'b1;
        if (step_q == 5'd0) begin
          state_d = ST_STORE;
        end
      end

      ST_STORE: begin
        mem_we  = 1'b1;
        count_d = count_q + 1'b1;
        // A stopped player stays stopped past the new entry
        if (!(ptr_q < count_q)) begin
          ptr_d = count_q + 1'b1;
        end
        state_d = ST_FINISH;
      end

      ST_TICK: begin
        if (!phase_q) begin
          if (rd_per_q[tsp_pkg::PER_W]) begin
            top_d    = tsp_pkg::TOP_MAX;
            active_d = 1'b0;
          end else begin
            top_d    = rd_per_q[tsp_pkg::PER_W-1:0];
            active_d = 1'b1;
          end
        end
        elapsed_d = el_next;
        phase_d   = 1'b1;
        // Advance when the entry's duration has run out
        if (!rd_dur_q[tsp_pkg::DUR_W] && (el_next >= rd_dur_q[tsp_pkg::DUR_W-1:0])) begin
          ptr_d   = ptr_inc;
          phase_d = 1'b0;
          if (ptr_inc >= count_q) begin
            top_d    = tsp_pkg::TOP_MAX;
            active_d = 1'b0;
          end
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {7'b0, full_q, tsp_pkg::IDX_W'(ptr_q), (ptr_q < count_q), active_q,
                         top_q[tsp_pkg::PER_W-1:1], top_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_q       <= tsp_pkg::REF_RESET;
      count_q     <= '0;
      ptr_q       <= '0;
      phase_q     <= 1'b0;
      elapsed_q   <= '0;
      top_q       <= tsp_pkg::TOP_MAX;
      active_q    <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ref_q       <= ref_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      top_q       <= top_d;
      active_q    <= active_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    use_note_q <= use_note_d;
    freq_in_q  <= freq_in_d;
    letter_q   <= letter_d;
    octave_q   <= octave_d;
    rest_q     <= rest_d;
    dur_q      <= dur_d;
    indef_q    <= indef_d;
    mcand_q    <= mcand_d;
    mpl_q      <= mpl_d;
    acc_q      <= acc_d;
    shamt_q    <= shamt_d;
    step_q     <= step_d;
    divisor_q  <= divisor_d;
    rem_q      <= rem_d;
    num_q      <= num_d;
  end

  // Store: write at the fill count, read at the play pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      per_mem[count_q[tsp_pkg::ADDR_W-1:0]] <= {rest_q, per_clamped};
      dur_mem[count_q[tsp_pkg::ADDR_W-1:0]] <= {indef_q, dur_q};
    end
    rd_per_q <= per_mem[ptr_q[tsp_pkg::ADDR_W-1:0]];
    rd_dur_q <= dur_mem[ptr_q[tsp_pkg::ADDR_W-1:0]];
  end

endmodule
